// ===== hdl/fuqp_pkg.sv =====
// Shared types, character codes and helper functions for the query parser.
`timescale 1ns / 1ps

package fuqp_pkg;

  // Space store depth: default and the largest supported value
  localparam int SPACE_FIFO_DEPTH_DEF = 16;
  localparam int SPACE_FIFO_DEPTH_MAX = 60;

  // Width of a space count or space index, sized for the largest store
  localparam int SP_CNT_W = $clog2(SPACE_FIFO_DEPTH_MAX + 1);

  // Depth of the command queue between front and back
  localparam int CMD_Q_DEPTH = 4;

  // Most literal bytes one input word can produce
  localparam int LIT_MAX = 3;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Escape progress codes
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       param_end;
    logic       space_overflow;
  } out_word_t;

  // Command from front to back: flush stored spaces, then literals, then marker
  typedef struct packed {
    logic [SP_CNT_W-1:0]     flush_cnt;
    logic [SP_CNT_W-1:0]     ws_idx;
    logic                    push_ws;
    logic [7:0]              ws_byte;
    logic [LIT_MAX-1:0][7:0] lit;
    logic [1:0]              lit_cnt;
    logic                    marker;
    logic                    close_param;
    logic                    in_value;
    logic                    space_overflow;
  } cmd_t;

  // Whitespace: space, TAB, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Hex digit check, either case
  function automatic logic hex_ok(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  // Hex digit value; letters map through the low nibble plus nine
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [3:0] v;
    if (b <= 8'h39) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== hdl/fuqp_front.sv =====
// Front end: accepts query words, tracks escape and parameter state, issues commands.
`timescale 1ns / 1ps

module fuqp_front
  import fuqp_pkg::*;
#(
  parameter int SpaceFifoDepth = SPACE_FIFO_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     q_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [1:0]          esc_len_q, esc_len_d;
  logic [7:0]          esc_raw_q, esc_raw_d;
  logic [3:0]          esc_hi_q, esc_hi_d;
  logic [SP_CNT_W-1:0] sp_cnt_q, sp_cnt_d;
  logic                seen_eq_q, seen_eq_d;
  logic                started_q, started_d;
  logic                ovf_q, ovf_d;

  logic                    in_acc;
  logic [7:0]              b;
  logic [LIT_MAX-1:0][7:0] lit;
  logic [1:0]              lit_cnt;
  logic [SP_CNT_W-1:0]     flush_cnt;
  logic                    push_ws;
  logic                    end_p;
  logic                    dec_done;
  logic                    seen_step;
  logic                    ovf_step;
  logic                    marker;
  logic                    cmd_needed;

  assign in_stall_o = q_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign b          = in_word_i.in_byte;

  // Classify the byte and work out its literals and the next state
  always_comb begin
    esc_len_d = esc_len_q;
    esc_raw_d = esc_raw_q;
    esc_hi_d  = esc_hi_q;
    sp_cnt_d  = sp_cnt_q;
    seen_eq_d = seen_eq_q;
    started_d = started_q;
    ovf_d     = ovf_q;
    lit       = '0;
    lit_cnt   = 2'd0;
    flush_cnt = '0;
    push_ws   = 1'b0;
    end_p     = 1'b0;
    dec_done  = 1'b0;

    if (b == CH_AMP) begin
      // parameter separator: close any open escape literally
      if (started_q) begin
        if (esc_len_q == ESC_PCT) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
        end else if (esc_len_q == ESC_HEX) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
          lit[lit_cnt] = esc_raw_q;
          lit_cnt      = lit_cnt + 2'd1;
        end
        end_p = 1'b1;
      end
    end else if (is_ws(b)) begin
      // whitespace breaks an escape and waits in the space store
      if (started_q) begin
        if (esc_len_q == ESC_PCT) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
        end else if (esc_len_q == ESC_HEX) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
          lit[lit_cnt] = esc_raw_q;
          lit_cnt      = lit_cnt + 2'd1;
        end
        esc_len_d = ESC_NONE;
        if (sp_cnt_q < SP_CNT_W'(SpaceFifoDepth)) begin
          push_ws  = !in_word_i.last;
          sp_cnt_d = sp_cnt_q + SP_CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
        if (in_word_i.last) begin
          end_p = 1'b1;
        end
      end
    end else begin
      // ordinary byte: pending spaces are interior, flush them first
      started_d = 1'b1;
      flush_cnt = sp_cnt_q;
      sp_cnt_d  = '0;
      if ((b == CH_EQ) && !seen_eq_q) begin
        if (esc_len_q == ESC_PCT) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
        end else if (esc_len_q == ESC_HEX) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
          lit[lit_cnt] = esc_raw_q;
          lit_cnt      = lit_cnt + 2'd1;
        end
        esc_len_d = ESC_NONE;
        seen_eq_d = 1'b1;
      end else begin
        // percent decoding
        if (esc_len_q == ESC_PCT) begin
          if (hex_ok(b)) begin
            esc_hi_d  = hex_nib(b);
            esc_raw_d = b;
            esc_len_d = ESC_HEX;
            dec_done  = 1'b1;
          end else begin
            lit[lit_cnt] = CH_PCT;
            lit_cnt      = lit_cnt + 2'd1;
          end
        end else if (esc_len_q == ESC_HEX) begin
          if (hex_ok(b)) begin
            lit[lit_cnt] = {esc_hi_q, hex_nib(b)};
            lit_cnt      = lit_cnt + 2'd1;
            esc_len_d    = ESC_NONE;
            dec_done     = 1'b1;
          end else begin
            lit[lit_cnt] = CH_PCT;
            lit_cnt      = lit_cnt + 2'd1;
            lit[lit_cnt] = esc_raw_q;
            lit_cnt      = lit_cnt + 2'd1;
          end
        end
        if (!dec_done) begin
          esc_len_d = ESC_NONE;
          if (b == CH_PLUS) begin
            lit[lit_cnt] = CH_SPACE;
            lit_cnt      = lit_cnt + 2'd1;
          end else if (b == CH_PCT) begin
            esc_len_d = ESC_PCT;
          end else begin
            lit[lit_cnt] = b;
            lit_cnt      = lit_cnt + 2'd1;
          end
        end
      end
      // end of string: any escape left open goes out literally
      if (in_word_i.last) begin
        if (esc_len_d == ESC_PCT) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
        end else if (esc_len_d == ESC_HEX) begin
          lit[lit_cnt] = CH_PCT;
          lit_cnt      = lit_cnt + 2'd1;
          lit[lit_cnt] = esc_raw_d;
          lit_cnt      = lit_cnt + 2'd1;
        end
        end_p = 1'b1;
      end
    end

    // flags as they stand at the end of the byte, before a parameter close
    seen_step = seen_eq_d;
    ovf_step  = ovf_d;

    if (end_p) begin
      esc_len_d = ESC_NONE;
      esc_raw_d = '0;
      esc_hi_d  = '0;
      sp_cnt_d  = '0;
      seen_eq_d = 1'b0;
      started_d = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  // Bare end marker only when the close produced nothing else
  assign marker     = end_p && (flush_cnt == '0) && (lit_cnt == 2'd0);
  assign cmd_needed = push_ws || (lit_cnt != 2'd0) || (flush_cnt != '0) || marker;
  assign cmd_push_o = in_acc && cmd_needed;

  always_comb begin
    cmd_o.flush_cnt      = flush_cnt;
    cmd_o.ws_idx         = sp_cnt_q;
    cmd_o.push_ws        = push_ws;
    cmd_o.ws_byte        = b;
    cmd_o.lit            = lit;
    cmd_o.lit_cnt        = lit_cnt;
    cmd_o.marker         = marker;
    cmd_o.close_param    = end_p;
    cmd_o.in_value       = marker ? seen_step : seen_eq_q;
    cmd_o.space_overflow = marker ? ovf_step : ovf_q;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_len_q <= ESC_NONE;
      esc_raw_q <= '0;
      esc_hi_q  <= '0;
      sp_cnt_q  <= '0;
      seen_eq_q <= 1'b0;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (in_acc) begin
      esc_len_q <= esc_len_d;
      esc_raw_q <= esc_raw_d;
      esc_hi_q  <= esc_hi_d;
      sp_cnt_q  <= sp_cnt_d;
      seen_eq_q <= seen_eq_d;
      started_q <= started_d;
      ovf_q     <= ovf_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (sp_cnt_q == '0) && (esc_len_q == ESC_NONE) && !seen_eq_q && !ovf_q)
    else $error("parser state left over outside a parameter");

  a_sp_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_cnt_q <= SP_CNT_W'(SpaceFifoDepth))
    else $error("space count beyond store depth");

  a_esc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_len_q == ESC_NONE) || (esc_len_q == ESC_PCT) || (esc_len_q == ESC_HEX))
    else $error("bad escape progress code");

endmodule

// ===== hdl/fuqp_cmd_fifo.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module fuqp_cmd_fifo
  import fuqp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int PtrW = $clog2(CMD_Q_DEPTH);
  localparam int CntW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t            slot_q [CMD_Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(CMD_Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CMD_Q_DEPTH))
    else $error("queue fill level out of range");

endmodule

// ===== hdl/fuqp_back.sv =====
// Back end: holds pending whitespace and expands commands into output words.
`timescale 1ns / 1ps

module fuqp_back
  import fuqp_pkg::*;
#(
  parameter int SpaceFifoDepth = SPACE_FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int IdxW = (SpaceFifoDepth > 1) ? $clog2(SpaceFifoDepth) : 1;
  localparam int PosW = $clog2(SpaceFifoDepth + LIT_MAX + 1);

  logic [7:0]      space_q [SpaceFifoDepth];
  logic [PosW-1:0] pos_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic [PosW-1:0] n_words;
  logic [PosW-1:0] flush_ext;
  logic [1:0]      lit_sel;
  logic            load;
  logic            emit;
  logic            last_word;
  logic            sp_sel;
  out_word_t       item;

  assign flush_ext = PosW'(cmd_i.flush_cnt);
  assign n_words   = flush_ext + PosW'(cmd_i.lit_cnt) + PosW'(cmd_i.marker);
  assign lit_sel   = 2'(pos_q - flush_ext);
  assign load      = !out_valid_q || !out_stall_i;
  assign last_word = (pos_q == (n_words - PosW'(1)));
  assign sp_sel    = (pos_q < flush_ext);

  // Step through the head command one word per cycle while the output is not stalled
  always_comb begin
    emit    = 1'b0;
    q_pop_o = 1'b0;
    if (q_valid_i && load) begin
      if (n_words == '0) begin
        q_pop_o = 1'b1;
      end else begin
        emit    = 1'b1;
        q_pop_o = last_word;
      end
    end
  end

  // Select the word at the current position: literals or marker; spaces come from the store
  always_comb begin
    item.byte_valid     = 1'b1;
    item.in_value       = cmd_i.in_value;
    item.space_overflow = cmd_i.space_overflow;
    item.param_end      = cmd_i.close_param && last_word;
    item.out_byte       = cmd_i.lit[lit_sel];
    if (!sp_sel && cmd_i.marker) begin
      item.out_byte   = '0;
      item.byte_valid = 1'b0;
    end
  end

  // Space store; written as the whitespace command retires
  always_ff @(posedge clk_i) begin
    if (q_pop_o && cmd_i.push_ws) begin
      space_q[cmd_i.ws_idx[IdxW-1:0]] <= cmd_i.ws_byte;
    end
  end

  // Output register; stored spaces are read straight into it
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (sp_sel) begin
        out_q.out_byte <= space_q[pos_q[IdxW-1:0]];
      end else begin
        out_q.out_byte <= item.out_byte;
      end
      out_q.byte_valid     <= item.byte_valid;
      out_q.in_value       <= item.in_value;
      out_q.param_end      <= item.param_end;
      out_q.space_overflow <= item.space_overflow;
    end
  end

  // Position counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= emit;
      end
      if (q_pop_o) begin
        pos_q <= '0;
      end else if (emit) begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_marker_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.byte_valid) |-> out_word_o.param_end)
    else $error("end marker without parameter end");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid_i |-> (pos_q == '0))
    else $error("position left nonzero with no command");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && (n_words != '0)) |-> (pos_q < n_words))
    else $error("position past end of command");

endmodule

// ===== hdl/form_urlencoded_query_parser.sv =====
// The first word of a byte passes through the command queue and the output register.
// Throughput: one byte per cycle in and one word per cycle out; the back end steps through
//   each queued command word by word and retires a whitespace-only command without a word, so
//   input stalls when the four-entry command queue fills behind multi-word commands
//   (space flushes, broken escapes) or behind output stalls.
// Reset: clears parser state, queue and output valid; the space store holds no reset.
`timescale 1ns / 1ps

module form_urlencoded_query_parser
  import fuqp_pkg::*;
#(
  parameter int SpaceFifoDepth = SPACE_FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic cmd_push;
  cmd_t cmd_in;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t cmd_head;

  // Classify bytes and issue commands
  fuqp_front #(
    .SpaceFifoDepth(SpaceFifoDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  // Decoupling queue
  fuqp_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (cmd_push),
    .push_cmd_i(cmd_in),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (cmd_head)
  );

  // Expand commands into output words
  fuqp_back #(
    .SpaceFifoDepth(SpaceFifoDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cmd_i      (cmd_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the form-urlencoded query parser: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
  import fuqp_pkg::*;

  localparam int SPACE_DEPTH  = SPACE_FIFO_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Run bookkeeping
  int items_sent    = 0;
  int words_checked = 0;
  int ends_seen     = 0;
  int ovf_words     = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int stall_run     = 0;
  bit idle_on       = 1'b1;

  // Parser model state, matches the block's reset
  logic [1:0] esc_len_q    = ESC_NONE;
  logic [7:0] esc_second_q = 8'h00;
  logic [3:0] esc_high_q   = 4'h0;
  logic [7:0] pend_ws [SPACE_DEPTH];
  int         pend_cnt     = 0;
  logic       eq_seen_q    = 1'b0;
  logic       started_q    = 1'b0;
  logic       ovf_q        = 1'b0;

  // Words produced by the current byte, and all decoded words still due
  out_word_t step_words[$];
  out_word_t decoded_due[$];

  // Bytes of one parameter under construction
  logic [7:0] chunk_bytes[$];

  form_urlencoded_query_parser #(
    .SpaceFifoDepth(SPACE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic logic is_space(input logic [7:0] b);
    case (b)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= "0" && b <= "9") begin
      d = 8'h10 | (b - 8'h30);
    end else if (b >= "a" && b <= "f") begin
      d = 8'h10 | (b - 8'h57);
    end else if (b >= "A" && b <= "F") begin
      d = 8'h10 | (b - 8'h37);
    end
    return d[4:0];
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic vld);
    out_word_t w;
    w.out_byte       = b;
    w.byte_valid     = vld;
    w.in_value       = eq_seen_q;
    w.param_end      = 1'b0;
    w.space_overflow = ovf_q;
    step_words = {step_words, w};
  endfunction

  // Pending '%' or '%h' goes out literally
  function automatic void flush_escape();
    if (esc_len_q == ESC_PCT) begin
      put_byte(CH_PCT, 1'b1);
    end else if (esc_len_q == ESC_HEX) begin
      put_byte(CH_PCT, 1'b1);
      put_byte(esc_second_q, 1'b1);
    end
    esc_len_q = ESC_NONE;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [4:0] h;
    h = hex_decode(b);
    if (esc_len_q == ESC_PCT && h[4]) begin
      esc_high_q   = h[3:0];
      esc_second_q = b;
      esc_len_q    = ESC_HEX;
    end else if (esc_len_q == ESC_HEX && h[4]) begin
      put_byte({esc_high_q, h[3:0]}, 1'b1);
      esc_len_q = ESC_NONE;
    end else begin
      // broken escape is emitted, then this byte is scanned fresh
      flush_escape();
      if (b == CH_PLUS) begin
        put_byte(CH_SPACE, 1'b1);
      end else if (b == CH_PCT) begin
        esc_len_q = ESC_PCT;
      end else begin
        put_byte(b, 1'b1);
      end
    end
  endfunction

  // End of parameter: drop pending spaces, tag the last word or send a bare marker
  function automatic void close_param();
    out_word_t w;
    pend_cnt = 0;
    flush_escape();
    if (step_words.size() == 0) begin
      put_byte(8'h00, 1'b0);
    end
    w = step_words[step_words.size() - 1];
    w.param_end = 1'b1;
    step_words[step_words.size() - 1] = w;
    esc_len_q    = ESC_NONE;
    esc_second_q = 8'h00;
    esc_high_q   = 4'h0;
    eq_seen_q    = 1'b0;
    started_q    = 1'b0;
    ovf_q        = 1'b0;
  endfunction

  function automatic void predict_word(input in_word_t w);
    int i;
    step_words.delete();
    if (w.in_byte == CH_AMP) begin
      if (started_q) begin
        close_param();
      end
    end else begin
      if (is_space(w.in_byte)) begin
        if (started_q) begin
          flush_escape();
          if (pend_cnt < SPACE_DEPTH) begin
            pend_ws[pend_cnt] = w.in_byte;
            pend_cnt++;
          end else begin
            ovf_q = 1'b1;
          end
        end
      end else begin
        // interior spaces are confirmed by a non-space byte
        started_q = 1'b1;
        for (i = 0; i < pend_cnt; i++) begin
          put_byte(pend_ws[i], 1'b1);
        end
        pend_cnt = 0;
        if (w.in_byte == CH_EQ && !eq_seen_q) begin
          flush_escape();
          eq_seen_q = 1'b1;
        end else begin
          decode_byte(w.in_byte);
        end
      end
      if (w.last && started_q) begin
        close_param();
      end
    end
    foreach (step_words[k]) begin
      decoded_due = {decoded_due, step_words[k]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    if (decoded_due.size() == 0) begin
      $error("out_word: no word expected, actual out_byte %0h", got.out_byte);
      fail_cnt++;
    end else begin
      want = decoded_due.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      cmp_field("in_value", 8'(want.in_value), 8'(got.in_value));
      cmp_field("param_end", 8'(want.param_end), 8'(got.param_end));
      cmp_field("space_overflow", 8'(want.space_overflow), 8'(got.space_overflow));
      words_checked++;
      if (want.param_end) ends_seen++;
      if (want.space_overflow) ovf_words++;
    end
  endfunction

  // Sample both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_word(in_word_i);
      if (out_valid_o && !out_stall_i) check_word(out_word_o);
    end
  end

  // Receiver stalls in bursts of random length, started only while idling is on
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, 13);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one word; valid stays high on return so back-to-back words need no gap
  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_word_t w;
    w.in_byte = b;
    w.last    = lst;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold off the sender until every decoded word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_due.size() != 0);
  endtask

  // Append one byte to the chunk under construction
  function automatic void add_byte(input logic [7:0] b);
    chunk_bytes = {chunk_bytes, b};
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) begin
      c = CH_SPACE;
    end else begin
      c = 8'h09 + 8'($urandom_range(0, 4));
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [7:0] c;
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) begin
      c = 8'h30 + 8'(v);
    end else if (v < 16) begin
      c = 8'h61 + 8'(v - 10);
    end else begin
      c = 8'h41 + 8'(v - 16);
    end
    return c;
  endfunction

  // Printable byte with no special meaning
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(33, 126));
    end while (c == CH_AMP || c == CH_PCT || c == CH_PLUS || c == CH_EQ);
    return c;
  endfunction

  // Append n random units of key or value text to the chunk
  task automatic add_text(input int n, input int run_max);
    int k;
    int r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 15);
      case (r)
        0, 1: repeat ($urandom_range(1, run_max)) add_byte(rand_space());
        2: begin
          add_byte(CH_PCT);
          add_byte(rand_hex());
          add_byte(rand_hex());
        end
        3: begin
          add_byte(CH_PCT);
          if ($urandom_range(0, 1)) add_byte(rand_hex());
          add_byte(rand_plain());
        end
        4: add_byte(CH_PLUS);
        5: add_byte(8'($urandom_range(0, 255)));
        6: add_byte(CH_EQ);
        default: add_byte(rand_plain());
      endcase
    end
  endtask

  // Send the chunk, closed by '&' or by the last flag on its final byte
  task automatic send_chunk(input bit end_by_last);
    int i;
    logic amp_last;
    if (end_by_last) begin
      if (chunk_bytes.size() == 0) add_byte(rand_plain());
      amp_last = 1'b1;
    end else begin
      add_byte(CH_AMP);
      amp_last = ($urandom_range(0, 7) == 0);
    end
    for (i = 0; i < chunk_bytes.size(); i++) begin
      send_byte(chunk_bytes[i], amp_last && (i == chunk_bytes.size() - 1));
    end
  endtask

  // One key[=value] parameter with optional surrounding whitespace
  task automatic send_param(input int max_len, input int run_max, input bit end_by_last);
    chunk_bytes.delete();
    repeat ($urandom_range(0, 2)) add_byte(rand_space());
    add_text($urandom_range(0, max_len), run_max);
    if ($urandom_range(0, 3) != 0) add_byte(CH_EQ);
    add_text($urandom_range(0, max_len), run_max);
    repeat ($urandom_range(0, 2)) add_byte(rand_space());
    send_chunk(end_by_last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked bytes: separators, escapes good and broken, markers, field extremes
  task automatic test_directed();
    send_byte(CH_AMP, 1'b0);         // '&' with no parameter open
    send_byte(CH_SPACE, 1'b0);       // leading whitespace
    send_byte(CH_PCT, 1'b0);
    send_byte("4", 1'b0);
    send_byte(CH_EQ, 1'b0);          // escape cut by the first '='
    send_byte(CH_EQ, 1'b0);          // second '=' is value text
    send_byte(CH_PCT, 1'b0);
    send_byte("6", 1'b0);
    send_byte("F", 1'b0);            // upper-case escape
    send_byte(CH_PLUS, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte(8'h0B, 1'b0);          // escape broken by whitespace
    send_byte(CH_PCT, 1'b0);
    send_byte("g", 1'b0);            // malformed escape
    send_byte(CH_PCT, 1'b0);
    send_byte("a", 1'b0);
    send_byte(CH_AMP, 1'b0);         // escape open at chunk end
    send_byte(CH_EQ, 1'b0);
    send_byte(CH_AMP, 1'b0);         // bare end marker
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);          // byte extremes, closed by last
    send_byte(CH_SPACE, 1'b1);       // last with no parameter open
    send_byte("x", 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h0D, 1'b1);          // trailing whitespace dropped at last
  endtask

  task automatic test_well_formed(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_param(4, 4, $urandom_range(0, 2) == 0);
    end
    idle_on = 1'b1;
  endtask

  // Whitespace runs around the store depth: full flushes and overflow
  task automatic test_long_spaces();
    repeat (2) begin
      chunk_bytes.delete();
      add_text(1, 2);
      repeat ($urandom_range(SPACE_DEPTH - 1, SPACE_DEPTH + 1)) begin
        add_byte(rand_space());
      end
      if ($urandom_range(0, 1)) add_byte(CH_PCT);
      add_byte(rand_plain());
      repeat ($urandom_range(SPACE_DEPTH + 1, SPACE_DEPTH + 2)) begin
        add_byte(rand_space());
      end
      send_chunk($urandom_range(0, 1) == 1);
    end
  endtask

  task automatic test_noise(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady(input int n);
    int target;
    target = items_sent + n;
    idle_on = 1'b0;
    while (items_sent < target) begin
      send_param(4, 3, $urandom_range(0, 2) == 0);
    end
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_well_formed(14);
    wait_drained();
    test_long_spaces();
    test_noise(8);
    test_steady(10);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d query bytes; checked %0d decoded words, %0d parameter ends,",
             items_sent, words_checked, ends_seen);
    $display("%0d words flagged with dropped whitespace.", ovf_words);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
